// ===== hdl/sliding_window_mean_stddev_top_defines.svh =====
// Assertion macros used by the checker file.
// Both expect clk and arst_n in the scope of use.
`ifndef SLIDING_WINDOW_MEAN_STDDEV_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEAN_STDDEV_TOP_DEFINES_SVH

// same-cycle implication
`define SWMS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SWMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/swms_pkg.sv =====
// ----------------------------------------------------------------------------
// swms_pkg
// Shared constants and control structs of the window statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package swms_pkg;

	localparam int OUT_W = 24;
	localparam int LANES = 3;
	localparam logic [7:0] WINDOW_RESET = 8'd100;

	// top -> lane control
	typedef struct packed {
		logic flush;
		logic start;
		logic ack;
	} lane_ctl_t;

	// lane -> top status
	typedef struct packed {
		logic busy;
		logic done;
	} lane_sts_t;

endpackage

`default_nettype wire

// ===== hdl/swms_ram.sv =====
// ----------------------------------------------------------------------------
// swms_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module swms_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 128
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/swms_div.sv =====
// ----------------------------------------------------------------------------
// swms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swms_div #(
	parameter int DW = 64,
	parameter int VW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic      [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [VW:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial = {rem_q[VW-1:0], quo_q[DW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? (trial - {1'b0, div_q}) : trial;
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== hdl/swms_sqrt.sv =====
// ----------------------------------------------------------------------------
// swms_sqrt
// Digit-recurrence integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swms_sqrt #(
	parameter int DW = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [DW-1:0]   value,
	output logic                 done,
	output logic      [DW/2-1:0] root
);

	localparam int HW = DW / 2;
	localparam int CW = $clog2(HW + 1);

	logic [HW+1:0] rem_q;
	logic [HW-1:0] root_q;
	logic [DW-1:0] val_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [HW+1:0] t;
	logic [HW+1:0] trial;
	logic          fits;

	assign t     = {rem_q[HW-1:0], val_q[DW-1:DW-2]};
	assign trial = {root_q, 2'b01};
	assign fits  = t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(HW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			val_q  <= value;
		end else if (run_q) begin
			rem_q  <= fits ? (t - trial) : t;
			root_q <= {root_q[HW-2:0], fits};
			val_q  <= {val_q[DW-3:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== hdl/swms_lane.sv =====
// ----------------------------------------------------------------------------
// swms_lane
// One statistics lane: sample ring, running sums, mean and stddev sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module swms_lane #(
	parameter int MAX_WINDOW  = 128,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire swms_pkg::lane_ctl_t          ctl,
	input  wire logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] slot,
	input  wire logic [$clog2(MAX_WINDOW + 1)-1:0] n,
	input  wire logic                         full,
	input  wire logic [SAMPLE_BITS-1:0]       sample,
	output swms_pkg::lane_sts_t               sts,
	output logic [swms_pkg::OUT_W-1:0]        mean,
	output logic [swms_pkg::OUT_W-1:0]        stddev
);

	localparam int SB   = SAMPLE_BITS;
	localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int NW   = $clog2(MAX_WINDOW + 1);
	localparam int SUMW = SB + NW;
	localparam int SQW  = 2 * SB + NW;
	localparam int DW   = 2 * SUMW;
	localparam int OW   = swms_pkg::OUT_W;

	typedef enum logic [8:0] {
		L_IDLE = 9'b000000001,
		L_UPD  = 9'b000000010,
		L_MUL  = 9'b000000100,
		L_SUB  = 9'b000001000,
		L_DIVM = 9'b000010000,
		L_DIVV = 9'b000100000,
		L_SQRT = 9'b001000000,
		L_DONE = 9'b010000000,
		L_WAIT = 9'b100000000
	} lane_state_t;

	lane_state_t    state_q;
	logic [SB-1:0]  samp_q;
	logic [AW-1:0]  slot_q;
	logic [NW-1:0]  n_q;
	logic           full_q;
	logic [SUMW-1:0] sum_q;
	logic [SQW-1:0] sumsq_q;
	logic [DW-1:0]  a_q;
	logic [DW-1:0]  b_q;
	logic [2*NW-1:0] nsq_q;
	logic [DW-1:0]  d_q;
	logic [OW-1:0]  mean_q;
	logic [OW-1:0]  sd_q;

	logic [SB-1:0]   old;
	logic [2*SB-1:0] old_sq;
	logic [2*SB-1:0] new_sq;
	logic [SUMW-1:0] old_ext;
	logic [SQW-1:0]  old_sq_ext;

	logic            div_start;
	logic [DW-1:0]   div_dividend;
	logic [2*NW-1:0] div_divisor;
	logic            div_done;
	logic [DW-1:0]   div_quo;
	logic            sqrt_start;
	logic            sqrt_done;
	logic [DW/2-1:0] sqrt_root;

	swms_ram #(
		.WIDTH(SB),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (state_q == L_UPD),
		.waddr(slot_q),
		.wdata(samp_q),
		.re   (ctl.start),
		.raddr(slot),
		.rdata(old)
	);

	assign old_sq     = old * old;
	assign new_sq     = samp_q * samp_q;
	assign old_ext    = full_q ? {{NW{1'b0}}, old} : '0;
	assign old_sq_ext = full_q ? {{NW{1'b0}}, old_sq} : '0;

	// first pass divides sum by n, second divides the spread by n*n
	assign div_start    = (state_q == L_SUB) || ((state_q == L_DIVM) && div_done);
	assign div_dividend = (state_q == L_SUB) ? {{(DW - SUMW){1'b0}}, sum_q} : d_q;
	assign div_divisor  = (state_q == L_SUB) ? {{NW{1'b0}}, n_q} : nsq_q;
	assign sqrt_start   = (state_q == L_DIVV) && div_done;

	swms_div #(
		.DW(DW),
		.VW(2 * NW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quo)
	);

	swms_sqrt #(
		.DW(DW)
	) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.value (div_quo),
		.done  (sqrt_done),
		.root  (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else begin
			if (ctl.flush) begin
				sum_q   <= '0;
				sumsq_q <= '0;
			end else if (state_q == L_UPD) begin
				sum_q   <= sum_q - old_ext + {{NW{1'b0}}, samp_q};
				sumsq_q <= sumsq_q - old_sq_ext + {{NW{1'b0}}, new_sq};
			end
			unique case (state_q)
				L_IDLE: if (ctl.start) state_q <= L_UPD;
				L_UPD:  state_q <= L_MUL;
				L_MUL:  state_q <= L_SUB;
				L_SUB:  state_q <= L_DIVM;
				L_DIVM: if (div_done) state_q <= L_DIVV;
				L_DIVV: if (div_done) state_q <= L_SQRT;
				L_SQRT: if (sqrt_done) state_q <= L_DONE;
				L_DONE: if (ctl.ack) state_q <= L_WAIT;
				L_WAIT: state_q <= ctl.start ? L_UPD : L_IDLE;
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			samp_q <= sample;
			slot_q <= slot;
			n_q    <= n;
			full_q <= full;
		end
		if (state_q == L_MUL) begin
			a_q   <= n_q * sumsq_q;
			b_q   <= sum_q * sum_q;
			nsq_q <= n_q * n_q;
		end
		if (state_q == L_SUB) begin
			d_q <= (a_q > b_q) ? (a_q - b_q) : '0;
		end
		if ((state_q == L_DIVM) && div_done) begin
			mean_q <= OW'(div_quo);
		end
		if (sqrt_done) begin
			sd_q <= OW'(sqrt_root);
		end
	end

	assign sts.busy = (state_q != L_IDLE) && (state_q != L_WAIT);
	assign sts.done = (state_q == L_DONE);
	assign mean     = mean_q;
	assign stddev   = sd_q;

endmodule

`default_nettype wire

// ===== hdl/sliding_window_mean_stddev_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_mean_stddev_top
// Moving-window mean and population stddev of three timing sample lanes.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with cut_sample, path_sample and
// refine_sample; one request carries one sample per lane. Output channel:
// out_valid/out_stall with floor mean and floor stddev per lane, one result
// per input request.
// window_length_we writes window_length (0 acts as 1, values above
// MAX_WINDOW saturate); every write restarts all windows empty. Write only
// while the block is idle.
// Each lane's run is set by its bit-serial divider (used twice) and square
// root. The lanes run side by side; one request is in flight at a time, so
// a new request is taken only once the lanes have handed over the last
// result.
// A finished result sits in the output register while the next request is
// taken; a stalled receiver holds the result and, once the next one is
// ready, holds the lanes too.
// Reset clears the windows and sums, sets window_length to 100 and drops
// any result in flight. Ring contents are not cleared; an entry read while
// the window is still filling is never used.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_mean_stddev_top #(
	parameter int MAX_WINDOW  = 128,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   window_length_we,
	input  wire logic [7:0]             window_length,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [SAMPLE_BITS-1:0] cut_sample,
	input  wire logic [SAMPLE_BITS-1:0] path_sample,
	input  wire logic [SAMPLE_BITS-1:0] refine_sample,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [swms_pkg::OUT_W-1:0]  cut_mean,
	output logic [swms_pkg::OUT_W-1:0]  path_mean,
	output logic [swms_pkg::OUT_W-1:0]  refine_mean,
	output logic [swms_pkg::OUT_W-1:0]  cut_stddev,
	output logic [swms_pkg::OUT_W-1:0]  path_stddev,
	output logic [swms_pkg::OUT_W-1:0]  refine_stddev
);

	localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int NW    = $clog2(MAX_WINDOW + 1);
	localparam int OW    = swms_pkg::OUT_W;
	localparam int LANES = swms_pkg::LANES;

	logic [7:0]    window_q;
	logic [NW-1:0] fill_q;
	logic [AW-1:0] oldest_q;
	logic          out_valid_q;

	logic [NW-1:0] w_eff;
	logic          full;
	logic [AW-1:0] slot;
	logic [NW-1:0] n;
	logic          accept;
	logic          load;

	swms_pkg::lane_ctl_t ctl;
	swms_pkg::lane_sts_t sts [LANES];
	logic [SAMPLE_BITS-1:0] samp [LANES];
	logic [OW-1:0] mean_w [LANES];
	logic [OW-1:0] sd_w   [LANES];
	logic [LANES-1:0] busy_v;
	logic [LANES-1:0] done_v;

	always_comb begin
		if (window_q == 8'd0) begin
			w_eff = NW'(1);
		end else if (32'(window_q) > MAX_WINDOW) begin
			w_eff = NW'(MAX_WINDOW);
		end else begin
			w_eff = NW'(window_q);
		end
	end

	// the oldest slot only moves once the window is full, so a filling
	// window writes at its fill position
	assign full   = (fill_q == w_eff);
	assign slot   = full ? oldest_q : AW'(fill_q);
	assign n      = full ? fill_q : (fill_q + 1'b1);
	assign accept = in_valid && !in_stall;
	assign load   = (&done_v) && (!out_valid_q || !out_stall);

	assign ctl.flush = window_length_we;
	assign ctl.start = accept;
	assign ctl.ack   = load;

	assign samp[0] = cut_sample;
	assign samp[1] = path_sample;
	assign samp[2] = refine_sample;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		swms_lane #(
			.MAX_WINDOW (MAX_WINDOW),
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.slot  (slot),
			.n     (n),
			.full  (full),
			.sample(samp[k]),
			.sts   (sts[k]),
			.mean  (mean_w[k]),
			.stddev(sd_w[k])
		);
		assign busy_v[k] = sts[k].busy;
		assign done_v[k] = sts[k].done;
	end

	assign in_stall = |busy_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= swms_pkg::WINDOW_RESET;
			fill_q      <= '0;
			oldest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (window_length_we) begin
				window_q <= window_length;
				fill_q   <= '0;
				oldest_q <= '0;
			end else if (accept) begin
				if (full) begin
					oldest_q <= ((NW'(oldest_q) + 1'b1) == w_eff) ? '0 : (oldest_q + 1'b1);
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cut_mean      <= mean_w[0];
			path_mean     <= mean_w[1];
			refine_mean   <= mean_w[2];
			cut_stddev    <= sd_w[0];
			path_stddev   <= sd_w[1];
			refine_stddev <= sd_w[2];
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/swms_checker.sv =====
// ----------------------------------------------------------------------------
// swms_checker
// Port-level assertions for the window statistics block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sliding_window_mean_stddev_top_defines.svh"

module swms_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [swms_pkg::OUT_W-1:0]    cut_mean,
	input wire logic [swms_pkg::OUT_W-1:0]    cut_stddev
);

	`SWMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`SWMS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(cut_mean) && $stable(cut_stddev))
	// one request in flight: the lanes are busy right after a request
	`SWMS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
	// a new result only comes from lanes that were holding it
	`SWMS_ASSERT_NOW(a_result_from_lanes, $rose(out_valid), $past(in_stall))

endmodule

bind sliding_window_mean_stddev_top swms_checker u_swms_checker (.*);

`default_nettype wire
